FILE: hdl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg: shared types and codes of the I2C master transfer sequencer
// Request codes, action-word codes, phase encoding and the request and
// action structures passed between the sequencer's modules.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Request types
  localparam logic [2:0] REQ_PLAIN_READ = 3'd0;
  localparam logic [2:0] REQ_REG_WRITE  = 3'd1;
  localparam logic [2:0] REQ_REG_READ   = 3'd2;
  localparam logic [2:0] REQ_STATUS     = 3'd3;
  localparam logic [2:0] REQ_ERROR      = 3'd4;

  // ACK control codes
  localparam logic [1:0] ACK_KEEP = 2'd0;
  localparam logic [1:0] ACK_ON   = 2'd1;
  localparam logic [1:0] ACK_OFF  = 2'd2;

  // Interrupt mask control codes
  localparam logic [1:0] IRQ_KEEP     = 2'd0;
  localparam logic [1:0] IRQ_BUF_ON   = 2'd1;
  localparam logic [1:0] IRQ_ALL_OFF  = 2'd2;
  localparam logic [1:0] IRQ_EVT_ONLY = 2'd3;

  // Completion codes
  localparam logic [1:0] DONE_NONE = 2'd0;
  localparam logic [1:0] DONE_OK   = 2'd1;
  localparam logic [1:0] DONE_FAIL = 2'd2;

  // Phase codes as reported on phase_now
  localparam logic [2:0] PHC_IDLE     = 3'd0;
  localparam logic [2:0] PHC_START    = 3'd1;
  localparam logic [2:0] PHC_START_RD = 3'd2;
  localparam logic [2:0] PHC_ADDRESS  = 3'd3;
  localparam logic [2:0] PHC_READING  = 3'd4;
  localparam logic [2:0] PHC_ERROR    = 3'd6;

  // Transfer phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_START    = 5'b00010,
    PH_START_RD = 5'b00100,
    PH_ADDRESS  = 5'b01000,
    PH_READING  = 5'b10000
  } phase_t;

  // Transfer context held between requests
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  target_addr;
    logic [7:0]  register_addr;
    logic [15:0] byte_count;
    logic [15:0] byte_index;
    logic        is_read;
  } seq_state_t;

  // One incoming request
  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  slave_addr;
    logic [7:0]  reg_addr;
    logic [15:0] length;
    logic        flag_sb;
    logic        flag_addr;
    logic        flag_btf;
    logic        flag_txe;
    logic        flag_rxne;
    logic        flag_ack_fail;
    logic [7:0]  data_byte;
  } req_t;

  // One action word
  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        gen_start;
    logic        gen_stop;
    logic [1:0]  ack_ctrl;
    logic [1:0]  irq_ctrl;
    logic        store_valid;
    logic [15:0] buffer_index;
    logic [7:0]  store_byte;
    logic [1:0]  done_res;
    logic [2:0]  phase_now;
  } act_t;

  // Map the one-hot phase to its reported code
  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_IDLE:     code = PHC_IDLE;
      PH_START:    code = PHC_START;
      PH_START_RD: code = PHC_START_RD;
      PH_ADDRESS:  code = PHC_ADDRESS;
      PH_READING:  code = PHC_READING;
      default:     code = PHC_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: hdl/i2cms_step.sv
// ----------------------------------------------------------------------------
// i2cms_step: action decode and next transfer context
// Turns one request and the current transfer context into one action word
// and the context that follows it.
// ----------------------------------------------------------------------------
module i2cms_step (
  input  i2cms_pkg::req_t       req,
  input  i2cms_pkg::seq_state_t cur,
  output i2cms_pkg::act_t       act,
  output i2cms_pkg::seq_state_t nxt
);

  logic done_ok;
  logic err;

  always_comb begin
    act     = '0;
    nxt     = cur;
    done_ok = 1'b0;
    err     = 1'b0;

    unique case (req.req_type) inside
      // Start a new transfer unless length is zero; abandon any running one
      i2cms_pkg::REQ_PLAIN_READ, i2cms_pkg::REQ_REG_WRITE, i2cms_pkg::REQ_REG_READ: begin
        if (req.length != 16'd0) begin
          nxt.target_addr   = req.slave_addr;
          nxt.register_addr = req.reg_addr;
          nxt.byte_count    = req.length;
          nxt.byte_index    = 16'd0;
          nxt.is_read       = (req.req_type != i2cms_pkg::REQ_REG_WRITE);
          nxt.phase         = (req.req_type == i2cms_pkg::REQ_PLAIN_READ) ?
                              i2cms_pkg::PH_START_RD : i2cms_pkg::PH_START;
          act.gen_start     = 1'b1;
          act.irq_ctrl      = i2cms_pkg::IRQ_EVT_ONLY;
        end
      end

      // Bus error: fail the transfer from any phase
      i2cms_pkg::REQ_ERROR: begin
        act.irq_ctrl = req.flag_ack_fail ? i2cms_pkg::IRQ_ALL_OFF : i2cms_pkg::IRQ_KEEP;
        act.done_res = i2cms_pkg::DONE_FAIL;
        nxt.phase    = i2cms_pkg::PH_IDLE;
        err          = 1'b1;
      end

      // Peripheral status event, ignored while idle
      i2cms_pkg::REQ_STATUS: begin
        if (cur.phase != i2cms_pkg::PH_IDLE) begin
          if (req.flag_sb) begin
            // Start sent: address the slave in the proper direction
            if (cur.phase == i2cms_pkg::PH_START) begin
              act.send_valid = 1'b1;
              act.send_byte  = {cur.target_addr[7:1], 1'b0};
              nxt.phase      = i2cms_pkg::PH_ADDRESS;
            end else if (cur.phase == i2cms_pkg::PH_START_RD) begin
              act.ack_ctrl   = i2cms_pkg::ACK_ON;
              act.send_valid = 1'b1;
              act.send_byte  = {cur.target_addr[7:1], 1'b1};
              nxt.phase      = i2cms_pkg::PH_READING;
            end
          end else if (req.flag_addr) begin
            // Address acknowledged: send register address, open buffer irq, ACK off if reading one byte
            if (cur.phase == i2cms_pkg::PH_ADDRESS) begin
              act.send_valid = 1'b1;
              act.send_byte  = cur.register_addr;
            end
            if (cur.byte_count == 16'd1 && cur.phase == i2cms_pkg::PH_READING) begin
              act.ack_ctrl = i2cms_pkg::ACK_OFF;
            end
            act.irq_ctrl = i2cms_pkg::IRQ_BUF_ON;
          end else if (req.flag_btf && req.flag_txe) begin
            if (cur.is_read) begin
              // Register sent: repeated start in read direction
              if (cur.phase == i2cms_pkg::PH_ADDRESS) begin
                act.gen_start = 1'b1;
                nxt.phase     = i2cms_pkg::PH_START_RD;
              end
            end else begin
              // Write: send next buffer byte
              act.send_valid   = 1'b1;
              act.send_byte    = req.data_byte;
              act.buffer_index = nxt.byte_index;
              nxt.byte_index   = nxt.byte_index + 16'd1;
              if (nxt.byte_index == cur.byte_count) begin
                act.irq_ctrl = i2cms_pkg::IRQ_ALL_OFF;
                act.gen_stop = 1'b1;
                done_ok      = 1'b1;
              end
            end
          end

          // Received byte: store it, drop ACK before the last one
          if (req.flag_rxne) begin
            act.store_valid  = 1'b1;
            act.store_byte   = req.data_byte;
            act.buffer_index = nxt.byte_index;
            nxt.byte_index   = nxt.byte_index + 16'd1;
            if (nxt.byte_index == cur.byte_count - 16'd1) begin
              act.ack_ctrl = i2cms_pkg::ACK_OFF;
            end
            if (nxt.byte_index == cur.byte_count) begin
              act.gen_stop = 1'b1;
              act.irq_ctrl = i2cms_pkg::IRQ_ALL_OFF;
              done_ok      = 1'b1;
            end
          end

          if (done_ok) begin
            act.done_res = i2cms_pkg::DONE_OK;
            nxt.phase    = i2cms_pkg::PH_IDLE;
          end
        end
      end

      default: ;
    endcase

    act.phase_now = err ? i2cms_pkg::PHC_ERROR : i2cms_pkg::phase_code(nxt.phase);
  end

endmodule

FILE: hdl/i2cms_out_buf.sv
// ----------------------------------------------------------------------------
// i2cms_out_buf: two-entry action word buffer
// Holds the result register and a skid entry so that new requests are
// taken while a finished action word waits for the consumer.
// ----------------------------------------------------------------------------
module i2cms_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  i2cms_pkg::act_t push_act,
  output logic            can_push,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cms_pkg::act_t out_act
);

  logic            full0;
  logic            full1;
  i2cms_pkg::act_t head;
  i2cms_pkg::act_t skid;
  logic            take;

  assign take      = full0 && out_ready;
  assign can_push  = !full1;
  assign out_valid = full0;
  assign out_act   = head;

  // Occupancy flags
  always_ff @(posedge clk) begin
    if (rst) begin
      full0 <= 1'b0;
      full1 <= 1'b0;
    end else if (take) begin
      if (full1) begin
        full1 <= 1'b0;
      end else begin
        full0 <= push;
      end
    end else if (push) begin
      if (full0) begin
        full1 <= 1'b1;
      end else begin
        full0 <= 1'b1;
      end
    end
  end

  // Payload: refill head from skid or from the new request
  always_ff @(posedge clk) begin
    if (take) begin
      if (full1) begin
        head <= skid;
      end else if (push) begin
        head <= push_act;
      end
    end else if (push) begin
      if (full0) begin
        skid <= push_act;
      end else begin
        head <= push_act;
      end
    end
  end

endmodule

FILE: hdl/i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer: I2C master register read/write sequencer
// Each request (start, status event or error) yields one action word that
// drives the I2C master peripheral through the transfer.
// ----------------------------------------------------------------------------
// One request is taken per clock while in_ready is high, and its action
// word is registered into the result buffer. The transfer context is
// updated by a single pass of decode logic at the edge that accepts the
// request, so back-to-back requests see each other's effects without stall.
// A two-entry result buffer sits at the output: in_ready drops only when
// both entries hold action words the consumer has not yet taken.
module i2c_master_transfer_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [7:0]  slave_addr,
  input  logic [7:0]  reg_addr,
  input  logic [15:0] length,
  input  logic        flag_sb,
  input  logic        flag_addr,
  input  logic        flag_btf,
  input  logic        flag_txe,
  input  logic        flag_rxne,
  input  logic        flag_ack_fail,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        send_valid,
  output logic [7:0]  send_byte,
  output logic        gen_start,
  output logic        gen_stop,
  output logic [1:0]  ack_ctrl,
  output logic [1:0]  irq_ctrl,
  output logic        store_valid,
  output logic [15:0] buffer_index,
  output logic [7:0]  store_byte,
  output logic [1:0]  done_res,
  output logic [2:0]  phase_now
);

  i2cms_pkg::req_t       req;
  i2cms_pkg::seq_state_t state;
  i2cms_pkg::seq_state_t state_next;
  i2cms_pkg::act_t       act;
  i2cms_pkg::act_t       out_act;
  logic                  accept;

  assign req = '{
    req_type:      req_type,
    slave_addr:    slave_addr,
    reg_addr:      reg_addr,
    length:        length,
    flag_sb:       flag_sb,
    flag_addr:     flag_addr,
    flag_btf:      flag_btf,
    flag_txe:      flag_txe,
    flag_rxne:     flag_rxne,
    flag_ack_fail: flag_ack_fail,
    data_byte:     data_byte
  };

  assign accept = in_valid && in_ready;

  // Decode the request against the current context
  i2cms_step u_step (
    .req (req),
    .cur (state),
    .act (act),
    .nxt (state_next)
  );

  // Hold the transfer context; advance on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= i2cms_pkg::PH_IDLE;
      state.target_addr   <= 8'd0;
      state.register_addr <= 8'd0;
      state.byte_count    <= 16'd0;
      state.byte_index    <= 16'd0;
      state.is_read       <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Buffer action words toward the consumer
  i2cms_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_act  (act),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_act   (out_act)
  );

  assign send_valid   = out_act.send_valid;
  assign send_byte    = out_act.send_byte;
  assign gen_start    = out_act.gen_start;
  assign gen_stop     = out_act.gen_stop;
  assign ack_ctrl     = out_act.ack_ctrl;
  assign irq_ctrl     = out_act.irq_ctrl;
  assign store_valid  = out_act.store_valid;
  assign buffer_index = out_act.buffer_index;
  assign store_byte   = out_act.store_byte;
  assign done_res     = out_act.done_res;
  assign phase_now    = out_act.phase_now;

endmodule

FILE: hdl/i2cms_checker.sv
// ----------------------------------------------------------------------------
// i2cms_checker: port-level checks of the transfer sequencer
// Watches the top level's ports for reset, buffering and completion rules.
// ----------------------------------------------------------------------------
module i2cms_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        gen_stop,
  input logic [15:0] buffer_index,
  input logic [1:0]  done_res,
  input logic [2:0]  phase_now
);

  // Reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // Back-pressure on the input only when a result is waiting
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result buffer");

  // A waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phase_now) && $stable(buffer_index))
    else $error("stalled result changed");

  // A failure always reports the error phase
  a_fail_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res == i2cms_pkg::DONE_FAIL |-> phase_now == i2cms_pkg::PHC_ERROR)
    else $error("failure without error phase");

  // A success ends with a stop and an idle phase
  a_ok_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res == i2cms_pkg::DONE_OK |->
      gen_stop && phase_now == i2cms_pkg::PHC_IDLE)
    else $error("success without stop or idle");

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_checker (.*);

FILE: dv/i2c_master_transfer_sequencer_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_chk: action word checker for the sequencer
// Watches both request and action channels, runs its own model of the
// transfer context for every accepted request and compares each accepted
// action word field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_chk
  import i2cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [7:0]  slave_addr,
  input  logic [7:0]  reg_addr,
  input  logic [15:0] length,
  input  logic        flag_sb,
  input  logic        flag_addr,
  input  logic        flag_btf,
  input  logic        flag_txe,
  input  logic        flag_rxne,
  input  logic        flag_ack_fail,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        send_valid,
  input  logic [7:0]  send_byte,
  input  logic        gen_start,
  input  logic        gen_stop,
  input  logic [1:0]  ack_ctrl,
  input  logic [1:0]  irq_ctrl,
  input  logic        store_valid,
  input  logic [15:0] buffer_index,
  input  logic [7:0]  store_byte,
  input  logic [1:0]  done_res,
  input  logic [2:0]  phase_now,
  output int          mismatches,
  output int          backlog
);

  // Model copy of the transfer context
  logic [2:0]  cur_phase;
  logic [7:0]  tgt_addr;
  logic [7:0]  reg_sel;
  logic [15:0] xfer_len;
  logic [15:0] xfer_idx;
  logic        rd_mode;

  act_t pending_actions[$];
  act_t want_act;
  act_t new_act;
  act_t got_act;
  req_t seen_req;
  int   action_num;

  assign seen_req = {req_type, slave_addr, reg_addr, length, flag_sb, flag_addr,
                     flag_btf, flag_txe, flag_rxne, flag_ack_fail, data_byte};
  assign got_act  = {send_valid, send_byte, gen_start, gen_stop, ack_ctrl, irq_ctrl,
                     store_valid, buffer_index, store_byte, done_res, phase_now};

  initial mismatches = 0;

  // Print one line per mismatch (first 40 only) and count every one
  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("[%0t] action %0d: %s", $realtime, action_num, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  // Work out the action word of one request and advance the context
  task automatic predict_action(input req_t rq, output act_t act);
    logic        finished;
    logic [15:0] last_idx;
    act = '0;
    finished = 1'b0;
    last_idx = xfer_len - 16'd1;
    if (rq.req_type <= REQ_REG_READ) begin
      // start request: zero length leaves everything as it is
      if (rq.length != 16'd0) begin
        tgt_addr = rq.slave_addr;
        reg_sel = rq.reg_addr;
        xfer_len = rq.length;
        xfer_idx = 16'd0;
        rd_mode = (rq.req_type != REQ_REG_WRITE);
        cur_phase = (rq.req_type == REQ_PLAIN_READ) ? PHC_START_RD : PHC_START;
        act.gen_start = 1'b1;
        act.irq_ctrl = IRQ_EVT_ONLY;
      end
      act.phase_now = cur_phase;
    end else if (rq.req_type == REQ_ERROR) begin
      act.irq_ctrl = rq.flag_ack_fail ? IRQ_ALL_OFF : IRQ_KEEP;
      act.done_res = DONE_FAIL;
      cur_phase = PHC_IDLE;
      act.phase_now = PHC_ERROR;
    end else if (rq.req_type == REQ_STATUS && cur_phase != PHC_IDLE) begin
      // start flag beats address flag beats byte-done flag
      if (rq.flag_sb) begin
        if (cur_phase == PHC_START) begin
          act.send_valid = 1'b1;
          act.send_byte = {tgt_addr[7:1], 1'b0};
          cur_phase = PHC_ADDRESS;
        end else if (cur_phase == PHC_START_RD) begin
          act.ack_ctrl = ACK_ON;
          act.send_valid = 1'b1;
          act.send_byte = {tgt_addr[7:1], 1'b1};
          cur_phase = PHC_READING;
        end
      end else if (rq.flag_addr) begin
        if (cur_phase == PHC_ADDRESS) begin
          act.send_valid = 1'b1;
          act.send_byte = reg_sel;
        end
        if (xfer_len == 16'd1 && cur_phase == PHC_READING) begin
          act.ack_ctrl = ACK_OFF;
        end
        act.irq_ctrl = IRQ_BUF_ON;
      end else if (rq.flag_btf && rq.flag_txe) begin
        if (rd_mode) begin
          // register sent: turn around with a repeated start
          if (cur_phase == PHC_ADDRESS) begin
            act.gen_start = 1'b1;
            cur_phase = PHC_START_RD;
          end
        end else begin
          act.send_valid = 1'b1;
          act.send_byte = rq.data_byte;
          act.buffer_index = xfer_idx;
          xfer_idx = xfer_idx + 16'd1;
          if (xfer_idx == xfer_len) begin
            act.irq_ctrl = IRQ_ALL_OFF;
            act.gen_stop = 1'b1;
            finished = 1'b1;
          end
        end
      end
      // received byte is handled on top of any of the above
      if (rq.flag_rxne) begin
        act.store_valid = 1'b1;
        act.store_byte = rq.data_byte;
        act.buffer_index = xfer_idx;
        xfer_idx = xfer_idx + 16'd1;
        if (xfer_idx == last_idx) begin
          act.ack_ctrl = ACK_OFF;
        end
        if (xfer_idx == xfer_len) begin
          act.gen_stop = 1'b1;
          act.irq_ctrl = IRQ_ALL_OFF;
          finished = 1'b1;
        end
      end
      if (finished) begin
        act.done_res = DONE_OK;
        cur_phase = PHC_IDLE;
      end
      act.phase_now = cur_phase;
    end else begin
      act.phase_now = cur_phase;
    end
  endtask

  // Compare accepted action words, then predict for the accepted request
  always @(posedge clk) begin
    if (rst) begin
      cur_phase = PHC_IDLE;
      tgt_addr = 8'd0;
      reg_sel = 8'd0;
      xfer_len = 16'd0;
      xfer_idx = 16'd0;
      rd_mode = 1'b0;
      action_num = 0;
      pending_actions.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_actions.size() == 0) begin
          report_mismatch("action word with no request waiting");
        end else begin
          want_act = pending_actions.pop_front();
          check_field("send_valid", 16'(got_act.send_valid), 16'(want_act.send_valid));
          check_field("send_byte", 16'(got_act.send_byte), 16'(want_act.send_byte));
          check_field("gen_start", 16'(got_act.gen_start), 16'(want_act.gen_start));
          check_field("gen_stop", 16'(got_act.gen_stop), 16'(want_act.gen_stop));
          check_field("ack_ctrl", 16'(got_act.ack_ctrl), 16'(want_act.ack_ctrl));
          check_field("irq_ctrl", 16'(got_act.irq_ctrl), 16'(want_act.irq_ctrl));
          check_field("store_valid", 16'(got_act.store_valid),
                      16'(want_act.store_valid));
          check_field("buffer_index", got_act.buffer_index, want_act.buffer_index);
          check_field("store_byte", 16'(got_act.store_byte), 16'(want_act.store_byte));
          check_field("done_res", 16'(got_act.done_res), 16'(want_act.done_res));
          check_field("phase_now", 16'(got_act.phase_now), 16'(want_act.phase_now));
        end
        action_num++;
      end
      if (in_valid && in_ready) begin
        predict_action(seen_req, new_act);
        pending_actions.push_back(new_act);
      end
    end
    backlog <= pending_actions.size();
  end

endmodule

FILE: dv/tb_i2c_master_transfer_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_master_transfer_sequencer: testbench of the I2C transfer sequencer
// Feeds directed requests (idle events, zero length, unknown codes, each
// transfer kind, restarts and errors) and then random transfers with noise,
// with random gaps on both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_i2c_master_transfer_sequencer;
  import i2cms_pkg::*;

  localparam int RANDOM_REQUESTS = 500;
  localparam int REQ_BITS = $bits(req_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  req_t drv_req = '0;
  bit   steady = 1'b0;
  int   sent_count = 0;

  logic        in_ready;
  logic        out_valid;
  logic        send_valid;
  logic [7:0]  send_byte;
  logic        gen_start;
  logic        gen_stop;
  logic [1:0]  ack_ctrl;
  logic [1:0]  irq_ctrl;
  logic        store_valid;
  logic [15:0] buffer_index;
  logic [7:0]  store_byte;
  logic [1:0]  done_res;
  logic [2:0]  phase_now;
  int          mismatches;
  int          backlog;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  i2c_master_transfer_sequencer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(drv_req.req_type), .slave_addr(drv_req.slave_addr),
    .reg_addr(drv_req.reg_addr), .length(drv_req.length),
    .flag_sb(drv_req.flag_sb), .flag_addr(drv_req.flag_addr),
    .flag_btf(drv_req.flag_btf), .flag_txe(drv_req.flag_txe),
    .flag_rxne(drv_req.flag_rxne), .flag_ack_fail(drv_req.flag_ack_fail),
    .data_byte(drv_req.data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .send_valid(send_valid), .send_byte(send_byte),
    .gen_start(gen_start), .gen_stop(gen_stop),
    .ack_ctrl(ack_ctrl), .irq_ctrl(irq_ctrl),
    .store_valid(store_valid), .buffer_index(buffer_index),
    .store_byte(store_byte), .done_res(done_res), .phase_now(phase_now)
  );

  i2c_master_transfer_sequencer_chk chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(drv_req.req_type), .slave_addr(drv_req.slave_addr),
    .reg_addr(drv_req.reg_addr), .length(drv_req.length),
    .flag_sb(drv_req.flag_sb), .flag_addr(drv_req.flag_addr),
    .flag_btf(drv_req.flag_btf), .flag_txe(drv_req.flag_txe),
    .flag_rxne(drv_req.flag_rxne), .flag_ack_fail(drv_req.flag_ack_fail),
    .data_byte(drv_req.data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .send_valid(send_valid), .send_byte(send_byte),
    .gen_start(gen_start), .gen_stop(gen_stop),
    .ack_ctrl(ack_ctrl), .irq_ctrl(irq_ctrl),
    .store_valid(store_valid), .buffer_index(buffer_index),
    .store_byte(store_byte), .done_res(done_res), .phase_now(phase_now),
    .mismatches(mismatches), .backlog(backlog)
  );

  // Mostly short gaps, a few long ones, none while in a steady stretch
  function automatic int pick_gap(input bit steady_mode);
    int r;
    r = $urandom_range(0, 99);
    if (steady_mode || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Fully random request, unknown codes and zero length included
  function automatic req_t noise_req();
    req_t rq;
    rq = REQ_BITS'({$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) rq.length = 16'd0;
    return rq;
  endfunction

  function automatic req_t start_req(input logic [2:0] kind, input logic [15:0] len);
    req_t rq;
    rq = noise_req();
    rq.req_type = kind;
    rq.length = len;
    return rq;
  endfunction

  function automatic req_t status_req(input bit sb, input bit ad, input bit btf,
                                      input bit txe, input bit rxne);
    req_t rq;
    rq = noise_req();
    rq.req_type = REQ_STATUS;
    rq.flag_sb = sb;
    rq.flag_addr = ad;
    rq.flag_btf = btf;
    rq.flag_txe = txe;
    rq.flag_rxne = rxne;
    return rq;
  endfunction

  // Present one request after a random gap and hold it until accepted
  task automatic send_request(input req_t rq);
    int gap;
    gap = pick_gap(steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drv_req <= rq;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // Peripheral event inside a transfer, now and then preceded by noise
  task automatic bus_event(input bit sb, input bit ad, input bit btf, input bit txe,
                           input bit rxne);
    req_t rq;
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      send_request(noise_req());
    end else if (r < 8) begin
      rq = noise_req();
      rq.req_type = REQ_ERROR;
      send_request(rq);
    end
    send_request(status_req(sb, ad, btf, txe, rxne | ($urandom_range(0, 49) == 0)));
  endtask

  // One well-formed transfer with random content; long ones are cut short
  task automatic run_transfer();
    logic [2:0]  kind;
    logic [15:0] len;
    int          r;
    int          n_data;
    r = $urandom_range(0, 2);
    kind = (r == 0) ? REQ_PLAIN_READ : (r == 1) ? REQ_REG_WRITE : REQ_REG_READ;
    r = $urandom_range(0, 19);
    if (r < 16) len = 16'($urandom_range(1, 6));
    else if (r < 18) len = 16'($urandom_range(7, 30));
    else len = 16'($urandom_range(1, 65535));
    n_data = (len > 16'd30) ? $urandom_range(0, 12) : int'(len);
    send_request(start_req(kind, len));
    bus_event(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    bus_event(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    if (kind == REQ_REG_READ) begin
      bus_event(1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
      bus_event(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      bus_event(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    end
    repeat (n_data) begin
      if (kind == REQ_REG_WRITE) bus_event(1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
      else bus_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    end
  endtask

  // Result side: random stalls of out_ready
  initial begin : result_stall
    int gap;
    @(posedge clk);
    forever begin
      gap = pick_gap(steady);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    req_t rq;
    int   directed;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // status events and unknown codes while idle: no action
    send_request(status_req(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    for (int c = REQ_ERROR + 1; c < 8; c++) begin
      rq = noise_req();
      rq.req_type = 3'(c);
      send_request(rq);
    end
    // zero length start is dropped
    send_request(start_req(REQ_REG_WRITE, 16'd0));

    // register write of two bytes, extreme addresses and data
    rq = start_req(REQ_REG_WRITE, 16'd2);
    rq.slave_addr = 8'hFF;
    rq.reg_addr = 8'h00;
    send_request(rq);
    send_request(status_req(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(status_req(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    rq = status_req(1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    rq.data_byte = 8'hFF;
    send_request(rq);
    rq.data_byte = 8'h00;
    send_request(rq);

    // register read of one byte with repeated start
    rq = start_req(REQ_REG_READ, 16'd1);
    rq.slave_addr = 8'h00;
    rq.reg_addr = 8'hFF;
    send_request(rq);
    send_request(status_req(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(status_req(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_request(status_req(1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    send_request(status_req(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(status_req(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_request(status_req(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));

    // plain read of three bytes, start flag together with a received byte
    send_request(start_req(REQ_PLAIN_READ, 16'd3));
    send_request(status_req(1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    send_request(status_req(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_request(status_req(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_request(status_req(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));

    // longest write abandoned by a new start, then errors busy and idle
    send_request(start_req(REQ_REG_WRITE, 16'hFFFF));
    send_request(status_req(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(start_req(REQ_REG_READ, 16'd2));
    rq = noise_req();
    rq.req_type = REQ_ERROR;
    rq.flag_ack_fail = 1'b1;
    send_request(rq);
    rq.flag_ack_fail = 1'b0;
    send_request(rq);

    // random transfers with noise, alternating steady and gappy stretches
    directed = sent_count;
    while (sent_count < directed + RANDOM_REQUESTS) begin
      if ($urandom_range(0, 9) == 0) steady = ~steady;
      if ($urandom_range(0, 9) == 0) send_request(noise_req());
      run_transfer();
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    // drain outstanding action words, the last request included
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** i2c_master_transfer_sequencer: PASSED **");
    end else begin
      $display("** i2c_master_transfer_sequencer: FAILED **");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs
  initial begin : watchdog
    #20ms;
    $display("** i2c_master_transfer_sequencer: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
hdl/i2cms_pkg.sv
hdl/i2cms_step.sv
hdl/i2cms_out_buf.sv
hdl/i2c_master_transfer_sequencer.sv
hdl/i2cms_checker.sv
dv/i2c_master_transfer_sequencer_chk.sv
dv/tb_i2c_master_transfer_sequencer.sv
